// ===== rtl/slcp_pkg.sv =====
package slcp_pkg;

    // Response codes carried on the result channel.
    localparam logic [2:0] RSP_OK     = 3'd0;
    localparam logic [2:0] RSP_ERR    = 3'd1;
    localparam logic [2:0] RSP_SERIAL = 3'd2;
    localparam logic [2:0] RSP_SWVER  = 3'd3;
    localparam logic [2:0] RSP_VER    = 3'd4;

    // Control characters.
    localparam logic [7:0] CHR_NUL = 8'h00;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_CR  = 8'h0D;

    // Command letters and argument characters.
    localparam logic [7:0] CMD_SERIAL  = 8'h4E;  // 'N'
    localparam logic [7:0] CMD_SWVER   = 8'h76;  // 'v'
    localparam logic [7:0] CMD_VER     = 8'h56;  // 'V'
    localparam logic [7:0] CMD_XMIT    = 8'h74;  // 't'
    localparam logic [7:0] CMD_CLOSE   = 8'h43;  // 'C'
    localparam logic [7:0] CMD_OPEN    = 8'h4F;  // 'O'
    localparam logic [7:0] CMD_BITRATE = 8'h53;  // 'S'
    localparam logic [7:0] CMD_BTR     = 8'h73;  // 's'
    localparam logic [7:0] CMD_TSTAMP  = 8'h5A;  // 'Z'
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_ONE     = 8'h31;
    localparam logic [7:0] CHR_SIX     = 8'h36;
    localparam logic [7:0] CHR_EIGHT   = 8'h38;

    // Positions of the transmit fields in the line.
    localparam int TX_ID_HI_POS = 2;
    localparam int TX_ID_LO_POS = 3;
    localparam int TX_LEN_POS   = 4;
    localparam int TX_DATA_POS  = 5;
    localparam int TX_LAST_POS  = 20;
    localparam int MAX_BYTES    = 8;

    // Hex digit value; anything that is not a hex digit reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/slcp_line_store.sv =====
module slcp_line_store #(
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;

    // Storage array with one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Per-entry valid bits make unwritten entries read as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

// ===== rtl/serial_line_command_parser.sv =====
// Channel   Direction  Handshake                 Payload
// rx        in         i_rx_valid / o_rx_stall    i_rx_char
// rsp       out        o_rsp_valid / i_rsp_stall  o_response, o_frame_valid, o_frame_id,
//                                                 o_frame_length, o_frame_data
//
// An ordinary character is written to the line store in the cycle of its transfer.
// A line end stalls the input: the store's single read port walks positions 0 through 20,
// a drain state captures the last read and a finish state decodes the command; when the
// finish state commits, any response goes to the output register and input is taken again.
// A finished response waits in the output register while new characters are taken;
// a second response waits in the decode cycle until the first one is transferred.
module serial_line_command_parser #(
    parameter int LINE_CAPACITY = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_char,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output logic [2:0]  o_response,
    output logic        o_frame_valid,
    output logic [7:0]  o_frame_id,
    output logic [3:0]  o_frame_length,
    output logic [63:0] o_frame_data
);

    import slcp_pkg::*;

    localparam int DEPTH = LINE_CAPACITY + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(LINE_CAPACITY + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TX_LAST_POS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state         r_state;
    logic [FW-1:0]  r_fill;
    logic           r_open;
    logic [AW-1:0]  r_addr;
    logic           r_pend;
    logic [AW-1:0]  r_pend_addr;
    logic [7:0]     r_cmd;
    logic [7:0]     r_c1;
    logic [7:0]     r_id;
    logic [3:0]     r_len;
    logic [63:0]    r_data;

    logic           r_out_valid;
    logic [2:0]     r_response;
    logic           r_frame_valid;
    logic [7:0]     r_frame_id;
    logic [3:0]     r_frame_length;
    logic [63:0]    r_frame_data;

    logic           rx_xfer;
    logic           out_xfer;
    logic           is_eol;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic [7:0]     rd_data;
    logic [3:0]     rd_hex;
    logic [3:0]     nib_sel;
    logic [3:0]     nib_pos;

    logic           has_rsp;
    logic [2:0]     n_response;
    logic           n_frame_valid;
    logic           n_open;
    logic [63:0]    masked_data;
    logic           commit;
    logic           load_rsp;

    assign rx_xfer  = i_rx_valid && !o_rx_stall;
    assign out_xfer = r_out_valid && !i_rsp_stall;
    assign is_eol   = (i_rx_char == CHR_CR) || (i_rx_char == CHR_LF);

    // Store writes: a character goes to the fill position, a line end leaves a zero there.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(r_fill);
        wr_data = i_rx_char;
        if (rx_xfer) begin
            if (is_eol) begin
                wr_en   = (r_fill != '0);
                wr_data = CHR_NUL;
            end else if (i_rx_char != CHR_NUL) begin
                wr_en = (r_fill < FW'(LINE_CAPACITY));
            end
        end
    end

    slcp_line_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Nibble placement for the data digits: high digit of a byte first.
    assign rd_hex  = hex_value(rd_data);
    assign nib_sel = 4'(r_pend_addr - AW'(TX_DATA_POS));
    assign nib_pos = {nib_sel[3:1], ~nib_sel[0]};

    // Data bytes beyond the length are cleared.
    always_comb begin
        masked_data = r_data;
        for (int k = 0; k < MAX_BYTES; k++) begin
            if (4'(k) >= r_len) begin
                masked_data[8*k +: 8] = 8'h00;
            end
        end
    end

    // Command decode over the gathered line.
    always_comb begin
        has_rsp       = 1'b1;
        n_response    = RSP_ERR;
        n_frame_valid = 1'b0;
        n_open        = r_open;
        unique case (r_cmd)
            CMD_SERIAL: n_response = RSP_SERIAL;
            CMD_SWVER:  n_response = RSP_SWVER;
            CMD_VER:    n_response = RSP_VER;
            CMD_XMIT: begin
                if (r_open && r_len != 4'd0 && r_len <= 4'(MAX_BYTES)) begin
                    n_response    = RSP_OK;
                    n_frame_valid = 1'b1;
                end else begin
                    has_rsp = 1'b0;
                end
            end
            CMD_CLOSE: begin
                n_open     = 1'b0;
                n_response = RSP_OK;
            end
            CMD_OPEN: begin
                if (r_fill == FW'(1)) begin
                    n_open     = 1'b1;
                    n_response = RSP_OK;
                end else begin
                    has_rsp = 1'b0;
                end
            end
            CMD_BITRATE: begin
                if (!r_open && ((r_c1 >= CHR_ZERO && r_c1 <= CHR_SIX) || r_c1 == CHR_EIGHT)) begin
                    n_response = RSP_OK;
                end
            end
            CMD_BTR: n_response = r_open ? RSP_ERR : RSP_OK;
            CMD_TSTAMP: begin
                if (r_fill == FW'(2) && (r_c1 == CHR_ZERO || r_c1 == CHR_ONE)) begin
                    n_response = RSP_OK;
                end
            end
            default: n_response = RSP_ERR;
        endcase
    end

    // The decode cycle may finish unless a response must wait for the output register.
    assign commit   = !has_rsp || !r_out_valid || !i_rsp_stall;
    assign load_rsp = (r_state == ST_FINISH) && commit && has_rsp;

    // Sequencer, line state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_open      <= 1'b0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= (r_state == ST_WALK);
            r_pend_addr <= r_addr;
            if (out_xfer && !load_rsp) begin
                r_out_valid <= 1'b0;
            end

            // Capture the bytes returned by the walk.
            if (r_pend) begin
                if (r_pend_addr == '0) begin
                    r_cmd <= rd_data;
                end
                if (r_pend_addr == AW'(1)) begin
                    r_c1 <= rd_data;
                end
                if (r_pend_addr == AW'(TX_ID_HI_POS)) begin
                    r_id[7:4] <= rd_hex;
                end
                if (r_pend_addr == AW'(TX_ID_LO_POS)) begin
                    r_id[3:0] <= rd_hex;
                end
                if (r_pend_addr == AW'(TX_LEN_POS)) begin
                    r_len <= rd_hex;
                end
                if (r_pend_addr >= AW'(TX_DATA_POS)) begin
                    r_data[{nib_pos, 2'b00} +: 4] <= rd_hex;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (rx_xfer) begin
                        if (is_eol) begin
                            if (r_fill != '0) begin
                                r_addr  <= '0;
                                r_state <= ST_WALK;
                            end
                        end else if (i_rx_char != CHR_NUL) begin
                            if (r_fill < FW'(LINE_CAPACITY)) begin
                                r_fill <= r_fill + FW'(1);
                            end else begin
                                r_fill <= '0;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (commit) begin
                        r_open  <= n_open;
                        r_fill  <= '0;
                        r_state <= ST_IDLE;
                        if (has_rsp) begin
                            r_out_valid    <= 1'b1;
                            r_response     <= n_response;
                            r_frame_valid  <= n_frame_valid;
                            r_frame_id     <= n_frame_valid ? r_id : 8'h00;
                            r_frame_length <= n_frame_valid ? r_len : 4'd0;
                            r_frame_data   <= n_frame_valid ? masked_data : 64'd0;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rx_stall     = (r_state != ST_IDLE);
    assign o_rsp_valid    = r_out_valid;
    assign o_response     = r_response;
    assign o_frame_valid  = r_frame_valid;
    assign o_frame_id     = r_frame_id;
    assign o_frame_length = r_frame_length;
    assign o_frame_data   = r_frame_data;

endmodule
